// File: rtl/bm25_pkg.sv
// ----------------------------------------------------------------------------
// bm25 package
// shared constants, types and command/status structs for the bm25 scorer
// ----------------------------------------------------------------------------
package bm25_pkg;

   localparam int TopK     = 16;
   localparam int TopBits  = $clog2(TopK);
   localparam int CntBits  = $clog2(TopK + 1);
   localparam logic [31:0] Ln2Q32 = 32'd2977044472;

   localparam logic [1:0] CSR_K1  = 2'd0;
   localparam logic [1:0] CSR_B   = 2'd1;
   localparam logic [1:0] CSR_N   = 2'd2;
   localparam logic [1:0] CSR_AVG = 2'd3;

   // one-hot controller states
   typedef enum logic [12:0] {
      ST_IDLE   = 13'b0000000000001,
      ST_LOGN   = 13'b0000000000010,
      ST_LOGD   = 13'b0000000000100,
      ST_IDF    = 13'b0000000001000,
      ST_QDIV   = 13'b0000000010000,
      ST_LEN    = 13'b0000000100000,
      ST_KL     = 13'b0000001000000,
      ST_TDIV   = 13'b0000010000000,
      ST_SCORE  = 13'b0000100000000,
      ST_ACC    = 13'b0001000000000,
      ST_SEARCH = 13'b0010000000000,
      ST_SHIFT  = 13'b0100000000000,
      ST_EMIT   = 13'b1000000000000
   } state_type;

   typedef struct packed {
      logic load;      // capture input word
      logic log_start; // start log unit
      logic log_sel;   // 0: 2N+2, 1: 2df+1
      logic log_save;  // store log result
      logic idf_mul;
      logic div_start;
      logic div_sel;   // 0: q division, 1: T division
      logic div_save;
      logic len_mul;
      logic kl_mul;
      logic score_mul;
      logic acc;
      logic search_clr;
      logic search_step;
      logic shift_step;
      logic place;
      logic emit_clr;
      logic emit_step;
      logic clear_tbl;
   } cmd_type;

   typedef struct packed {
      logic zero_term;  // tf/df zero or df > N
      logic log_done;
      logic div_done;
      logic close_doc;  // end of doc or query
      logic end_query;
      logic insert_ok;  // sum positive
      logic search_end; // position found
      logic pos_valid;  // position below TopK
      logic shift_end;
      logic tbl_empty;
      logic emit_last;
   } sts_type;

endpackage

// File: rtl/bm25_ctrl.sv
// ----------------------------------------------------------------------------
// bm25 controller
// sequences the log, divide and multiply steps, the top-k table update and the result emit
// ----------------------------------------------------------------------------
module bm25_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               rsp_busy,
   output logic               rsp_go,
   input  bm25_pkg::sts_type  sts,
   output bm25_pkg::cmd_type  cmd
);
   bm25_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= bm25_pkg::ST_IDLE;
      else state_ff <= state_in;
   end

   assign req_stall = (state_ff != bm25_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      rsp_go = 1'b0;
      case (state_ff)
         bm25_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = bm25_pkg::ST_LOGN;
            end
         end
         bm25_pkg::ST_LOGN: begin
            // the cycle after load: check zero term
            if (sts.zero_term) state_in = bm25_pkg::ST_ACC;
            else begin
               cmd.log_start = 1'b1;
               state_in = bm25_pkg::ST_LOGD;
            end
         end
         bm25_pkg::ST_LOGD: begin
            cmd.log_sel = 1'b0;
            if (sts.log_done) begin
               cmd.log_save = 1'b1;
               cmd.log_start = 1'b1;
               cmd.log_sel = 1'b1;
               cmd.div_start = 1'b1;
               state_in = bm25_pkg::ST_IDF;
            end
         end
         bm25_pkg::ST_IDF: begin
            cmd.log_sel = 1'b1;
            if (sts.log_done) begin
               cmd.log_save = 1'b1;
               state_in = bm25_pkg::ST_QDIV;
            end
         end
         bm25_pkg::ST_QDIV: begin
            cmd.idf_mul = 1'b1;
            if (sts.div_done) begin
               cmd.div_save = 1'b1;
               state_in = bm25_pkg::ST_LEN;
            end
         end
         bm25_pkg::ST_LEN: begin
            cmd.len_mul = 1'b1;
            state_in = bm25_pkg::ST_KL;
         end
         bm25_pkg::ST_KL: begin
            cmd.kl_mul = 1'b1;
            state_in = bm25_pkg::ST_TDIV;
         end
         bm25_pkg::ST_TDIV: begin
            cmd.div_sel = 1'b1;
            cmd.div_start = 1'b1;
            state_in = bm25_pkg::ST_SCORE;
         end
         bm25_pkg::ST_SCORE: begin
            cmd.div_sel = 1'b1;
            if (sts.div_done) begin
               cmd.div_save = 1'b1;
               cmd.score_mul = 1'b1;
               state_in = bm25_pkg::ST_ACC;
            end
         end
         bm25_pkg::ST_ACC: begin
            cmd.acc = 1'b1;
            cmd.search_clr = 1'b1;
            if (sts.close_doc) state_in = bm25_pkg::ST_SEARCH;
            else state_in = bm25_pkg::ST_IDLE;
         end
         bm25_pkg::ST_SEARCH: begin
            if (!sts.insert_ok) begin
               cmd.emit_clr = 1'b1;
               state_in = sts.end_query ? bm25_pkg::ST_EMIT : bm25_pkg::ST_IDLE;
            end else if (sts.search_end) begin
               if (sts.pos_valid) state_in = bm25_pkg::ST_SHIFT;
               else begin
                  cmd.emit_clr = 1'b1;
                  state_in = sts.end_query ? bm25_pkg::ST_EMIT : bm25_pkg::ST_IDLE;
               end
            end else cmd.search_step = 1'b1;
         end
         bm25_pkg::ST_SHIFT: begin
            if (sts.shift_end) begin
               cmd.place = 1'b1;
               cmd.emit_clr = 1'b1;
               state_in = sts.end_query ? bm25_pkg::ST_EMIT : bm25_pkg::ST_IDLE;
            end else cmd.shift_step = 1'b1;
         end
         bm25_pkg::ST_EMIT: begin
            if (sts.tbl_empty) state_in = bm25_pkg::ST_IDLE;
            else if (!rsp_busy) begin
               rsp_go = 1'b1;
               cmd.emit_step = 1'b1;
               if (sts.emit_last) begin
                  cmd.clear_tbl = 1'b1;
                  state_in = bm25_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = bm25_pkg::ST_IDLE;
      endcase
   end
endmodule

// File: rtl/bm25_dp.sv
// ----------------------------------------------------------------------------
// bm25 datapath
// log2 unit, shared restoring divider, multipliers, accumulator, top-k table
// ----------------------------------------------------------------------------
module bm25_dp (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   input  logic [31:0]        req_doc_id,
   input  logic [15:0]        req_term_freq,
   input  logic [23:0]        req_doc_len,
   input  logic [31:0]        req_doc_freq,
   input  logic               req_last_of_doc,
   input  logic               req_last_of_query,
   input  bm25_pkg::cmd_type  cmd,
   output bm25_pkg::sts_type  sts,
   output logic [31:0]        out_doc,
   output logic [31:0]        out_score,
   output logic               out_last
);
   // configuration
   logic [13:0] k1_ff;
   logic [12:0] b_ff;
   logic [31:0] n_ff, avg_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         k1_ff <= 14'd4915; b_ff <= 13'd3072; n_ff <= '0; avg_ff <= 32'd256;
      end else if (csr_valid) begin
         case (csr_index)
            bm25_pkg::CSR_K1:  k1_ff  <= csr_wdata[13:0];
            bm25_pkg::CSR_B:   b_ff   <= csr_wdata[12:0];
            bm25_pkg::CSR_N:   n_ff   <= csr_wdata;
            bm25_pkg::CSR_AVG: avg_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // captured word
   logic [31:0] id_ff, df_ff;
   logic [15:0] tf_ff;
   logic [23:0] dl_ff;
   logic        eod_ff, eoq_ff;
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff <= req_doc_id; tf_ff <= req_term_freq; dl_ff <= req_doc_len;
         df_ff <= req_doc_freq; eod_ff <= req_last_of_doc; eoq_ff <= req_last_of_query;
      end
   end
   assign sts.zero_term = (tf_ff == '0) || (df_ff == '0) || (df_ff > n_ff);
   assign sts.close_doc = eod_ff | eoq_ff;
   assign sts.end_query = eoq_ff;

   // log2 unit: one squaring per cycle, 16 steps
   logic [33:0] lv;
   logic [5:0]  le;
   logic [31:0] lm_ff;
   logic [15:0] lf_ff;
   logic [5:0]  le_ff;
   logic [4:0]  lc_ff;
   logic        lbusy_ff;
   logic [63:0] sq;
   logic [33:0] lnorm;
   assign lv = cmd.log_sel ? {1'b0, df_ff, 1'b1} : ({2'b0, n_ff} + 34'd1) << 1;
   always_comb begin
      le = '0;
      for (int i = 0; i < 34; i++) if (lv[i]) le = 6'(i);
   end
   assign lnorm = (le >= 6'd30) ? (lv >> (le - 6'd30)) : (lv << (6'd30 - le));
   assign sq = (64'(lm_ff) * 64'(lm_ff)) >> 30;
   always_ff @(posedge clock) begin
      if (reset) lbusy_ff <= 1'b0;
      else if (cmd.log_start) lbusy_ff <= 1'b1;
      else if (lbusy_ff && lc_ff == 5'd15) lbusy_ff <= 1'b0;
      if (cmd.log_start) begin
         lm_ff <= lnorm[31:0]; le_ff <= le; lf_ff <= '0; lc_ff <= '0;
      end else if (lbusy_ff) begin
         lc_ff <= lc_ff + 5'd1;
         if (sq[31]) begin lm_ff <= sq[32:1]; lf_ff <= {lf_ff[14:0], 1'b1}; end
         else begin lm_ff <= sq[31:0]; lf_ff <= {lf_ff[14:0], 1'b0}; end
      end
   end
   logic ldone_ff;
   always_ff @(posedge clock) begin
      if (reset) ldone_ff <= 1'b0;
      else ldone_ff <= lbusy_ff && lc_ff == 5'd15;
   end
   assign sts.log_done = ldone_ff;

   // the N run is saved while the df run starts, the df run is saved alone
   logic [21:0] lnum_ff, lden_ff;
   always_ff @(posedge clock) begin
      if (cmd.log_save) begin
         if (cmd.log_sel && !cmd.log_start) lden_ff <= {le_ff, lf_ff};
         else lnum_ff <= {le_ff, lf_ff};
      end
   end

   // idf: difference (< 2^22) times ln2 in two 16-bit halves
   logic [21:0] ld;
   logic [53:0] idf_full;
   logic [21:0] idf_ff;
   assign ld = lnum_ff - lden_ff;
   assign idf_full = 54'(ld) * 54'(bm25_pkg::Ln2Q32[31:16]) * 54'd65536
                   + 54'(ld) * 54'(bm25_pkg::Ln2Q32[15:0]);
   always_ff @(posedge clock)
      if (cmd.idf_mul) idf_ff <= 22'((idf_full + 54'h80000000) >> 32);

   // shared restoring divider, one quotient bit per cycle, 56-bit dividend
   logic [55:0] dq_ff;
   logic [52:0] dr_ff, dd_ff;
   logic [5:0]  dc_ff;
   logic        dbusy_ff, ddone_ff;
   logic [52:0] trial;
   logic [31:0] avg_eff;
   logic [12:0] b_eff;
   logic [30:0] num_t;
   logic [52:0] den_t;
   logic [49:0] kl_ff;
   assign avg_eff = (avg_ff == '0) ? 32'd1 : avg_ff;
   assign b_eff = (b_ff > 13'd4096) ? 13'd4096 : b_ff;
   assign num_t = 31'(tf_ff) * 31'(k1_ff + 15'd4096);
   assign den_t = 53'({tf_ff, 16'b0}) + 53'(kl_ff);
   assign trial = {dr_ff[51:0], dq_ff[55]};
   always_ff @(posedge clock) begin
      if (reset) begin dbusy_ff <= 1'b0; ddone_ff <= 1'b0; end
      else begin
         ddone_ff <= dbusy_ff && dc_ff == 6'd55;
         if (cmd.div_start) dbusy_ff <= 1'b1;
         else if (dc_ff == 6'd55) dbusy_ff <= 1'b0;
      end
      if (cmd.div_start) begin
         dq_ff <= cmd.div_sel ? {5'b0, num_t, 20'b0} : {8'b0, dl_ff, 24'b0};
         dd_ff <= cmd.div_sel ? den_t : 53'(avg_eff);
         dr_ff <= '0; dc_ff <= '0;
      end else if (dbusy_ff) begin
         dc_ff <= dc_ff + 6'd1;
         if (trial >= dd_ff) begin
            dr_ff <= trial - dd_ff; dq_ff <= {dq_ff[54:0], 1'b1};
         end else begin
            dr_ff <= trial; dq_ff <= {dq_ff[54:0], 1'b0};
         end
      end
   end
   assign sts.div_done = ddone_ff;

   // length norm and k1 * L
   logic [48:0] q_ff;  // q < 2^48
   logic [47:0] len_ff;
   logic [31:0] t_ff;
   logic [61:0] bq;
   always_ff @(posedge clock)
      if (cmd.div_save && !cmd.div_sel) q_ff <= 49'(dq_ff);
   assign bq = 62'(b_eff) * 62'(q_ff);
   always_ff @(posedge clock) begin
      if (cmd.len_mul)
         len_ff <= 48'(((62'(13'd4096 - b_eff) << 16) + bq) >> 12);
      if (cmd.kl_mul) kl_ff <= 50'((62'(k1_ff) * 62'(len_ff)) >> 12);
   end

   // term score: T <= (k1+4096)*16 < 2^19, well within the 35 bits kept
   logic [34:0] tq;
   logic [56:0] prod;
   logic [31:0] term_ff;
   assign tq = 35'(dq_ff);
   assign prod = 57'(idf_ff) * 57'(tq);
   always_ff @(posedge clock) begin
      if (cmd.load) term_ff <= '0;
      else if (cmd.score_mul) begin
         logic [56:0] r;
         r = (prod + 57'd32768) >> 16;
         term_ff <= (r[56:32] != '0) ? 32'hFFFFFFFF : r[31:0];
      end
   end
   assign t_ff = term_ff;

   // accumulator
   logic [31:0] sum_ff, cur_ff;
   logic [32:0] sum_nx;
   assign sum_nx = 33'(sum_ff) + 33'(t_ff);
   always_ff @(posedge clock) begin
      if (reset) sum_ff <= '0;
      else if (cmd.acc) begin
         if (sts.close_doc) begin
            sum_ff <= '0;
            cur_ff <= sum_nx[32] ? 32'hFFFFFFFF : sum_nx[31:0];
         end else sum_ff <= sum_nx[32] ? 32'hFFFFFFFF : sum_nx[31:0];
      end
   end
   assign sts.insert_ok = (cur_ff != '0);

   // top-k table in registers, search and shift one entry per cycle
   logic [31:0] ids_ff [bm25_pkg::TopK];
   logic [31:0] scs_ff [bm25_pkg::TopK];
   logic [bm25_pkg::CntBits-1:0] cnt_ff, pos_ff, sh_ff, em_ff;
   logic [bm25_pkg::TopBits-1:0] pidx, sidx, eidx;
   logic ranks_ahead;
   assign pidx = pos_ff[bm25_pkg::TopBits-1:0];
   assign sidx = sh_ff[bm25_pkg::TopBits-1:0];
   assign eidx = em_ff[bm25_pkg::TopBits-1:0];
   assign ranks_ahead = (cur_ff != scs_ff[pidx]) ? (cur_ff > scs_ff[pidx])
                                                : (id_ff < ids_ff[pidx]);
   assign sts.search_end = (pos_ff >= cnt_ff) || ranks_ahead;
   assign sts.pos_valid = pos_ff < bm25_pkg::CntBits'(bm25_pkg::TopK);
   assign sts.shift_end = sh_ff <= pos_ff;
   assign sts.tbl_empty = (cnt_ff == '0);
   assign sts.emit_last = (em_ff + 1'b1 == cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else if (cmd.clear_tbl) cnt_ff <= '0;
      else if (cmd.place && cnt_ff < bm25_pkg::CntBits'(bm25_pkg::TopK))
         cnt_ff <= cnt_ff + 1'b1;
      if (cmd.search_clr) pos_ff <= '0;
      else if (cmd.search_step) pos_ff <= pos_ff + 1'b1;
      if (cmd.search_clr)
         sh_ff <= (cnt_ff < bm25_pkg::CntBits'(bm25_pkg::TopK)) ? cnt_ff
                  : bm25_pkg::CntBits'(bm25_pkg::TopK - 1);
      else if (cmd.shift_step) begin
         sh_ff <= sh_ff - 1'b1;
         ids_ff[sidx] <= ids_ff[sidx - 1'b1];
         scs_ff[sidx] <= scs_ff[sidx - 1'b1];
      end
      if (cmd.place) begin ids_ff[pidx] <= id_ff; scs_ff[pidx] <= cur_ff; end
      if (cmd.emit_clr) em_ff <= '0;
      else if (cmd.emit_step) em_ff <= em_ff + 1'b1;
   end

   assign out_doc = ids_ff[eidx];
   assign out_score = scs_ff[eidx];
   assign out_last = sts.emit_last;
endmodule

// File: rtl/bm25_score_rank_core.sv
// ----------------------------------------------------------------------------
// bm25 score rank core
// okapi bm25 term scoring with per-document sums and a sorted top-k table
// ----------------------------------------------------------------------------
// a scored word takes two log2 runs, two restoring divisions and the multiply steps before
//   the next accept; a zero term skips them and goes straight to the accumulate step
// a closing word then goes on to the table search and shift
// one word is in work at a time; the shared bit-serial divider does both divisions
// end of query emits one result word per cycle while rsp_stall is low
// reset: synchronous; clears state, sum, table count, busy flags, valid; sets config defaults
module bm25_score_rank_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_doc_id,
   input  logic [15:0] req_term_freq,
   input  logic [23:0] req_doc_len,
   input  logic [31:0] req_doc_freq,
   input  logic        req_last_of_doc,
   input  logic        req_last_of_query,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_ranked_doc,
   output logic [31:0] rsp_doc_score,
   output logic        rsp_last_rank,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   bm25_pkg::cmd_type cmd;
   bm25_pkg::sts_type sts;
   logic        go;
   logic [31:0] odoc, oscore;
   logic        olast;

   // config always accepted
   assign csr_ready = 1'b1;

   bm25_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_busy(rsp_valid && rsp_stall), .rsp_go(go), .sts(sts), .cmd(cmd)
   );

   bm25_dp u_dp (
      .clock(clock), .reset(reset), .csr_valid(csr_valid), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_doc_id(req_doc_id), .req_term_freq(req_term_freq),
      .req_doc_len(req_doc_len), .req_doc_freq(req_doc_freq),
      .req_last_of_doc(req_last_of_doc), .req_last_of_query(req_last_of_query),
      .cmd(cmd), .sts(sts), .out_doc(odoc), .out_score(oscore), .out_last(olast)
   );

   // output register
   logic        vld_ff;
   logic [31:0] doc_ff, sc_ff;
   logic        last_ff;
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (go) vld_ff <= 1'b1;
      else if (!rsp_stall) vld_ff <= 1'b0;
      if (go) begin doc_ff <= odoc; sc_ff <= oscore; last_ff <= olast; end
   end
   assign rsp_valid = vld_ff;
   assign rsp_ranked_doc = doc_ff;
   assign rsp_doc_score = sc_ff;
   assign rsp_last_rank = last_ff;
endmodule

// File: rtl/bm25_chk.sv
// ----------------------------------------------------------------------------
// bm25 checker
// port-level checks on the scorer, bound to the top level
// ----------------------------------------------------------------------------
module bm25_chk (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_doc_score,
   input logic        rsp_last_rank
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_doc_score))
      else $error("stalled result changed");
   a_last_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_last_rank))
      else $error("stalled last flag changed");
   a_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_doc_score != 32'd0)
      else $error("zero score ranked");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("accepted word did not start work");
endmodule

bind bm25_score_rank_core bm25_chk u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_doc_score(rsp_doc_score),
   .rsp_last_rank(rsp_last_rank)
);
